// ----- design/force_pi_velocity_controller_macros.svh -----
// Assertion macros for the force PI velocity controller checker.
// Self-contained; taken in by the checker file only.
`ifndef FORCE_PI_VELOCITY_CONTROLLER_MACROS_SVH
`define FORCE_PI_VELOCITY_CONTROLLER_MACROS_SVH

// same-cycle implication
`define FPVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fpvc checker: property failed");

// next-cycle implication
`define FPVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fpvc checker: property failed");

`endif

// ----- design/fpvc_pkg.sv -----
// Shared types, constants and helper functions for the force PI velocity controller.
// No dependencies.
`default_nettype none

package fpvc_pkg;

	localparam int SINE_TABLE_SIZE_DEF = 256;
	localparam int DATA_W    = 32;
	localparam int DT_W      = 16;
	localparam int ELAPSED_W = 18;
	localparam int ADDR_W    = 4;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int SUM_W     = 52;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_POS_GAIN = 2'd1,
		REG_KP       = 2'd2,
		REG_KI       = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_PASSIVE = 2'd0,
		MODE_OPER    = 2'd1,
		MODE_CAL     = 2'd2,
		MODE_SPARE   = 2'd3
	} mode_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] res;
		if (&v[SUM_W-1:DATA_W-1] || ~|v[SUM_W-1:DATA_W-1])
			res = v[DATA_W-1:0];
		else if (v[SUM_W-1])
			res = {1'b1, {(DATA_W-1){1'b0}}};
		else
			res = {1'b0, {(DATA_W-1){1'b1}}};
		return res;
	endfunction

	// 2*sin of a 32-bit phase word, Q16.16; elaboration only
	function automatic logic signed [DATA_W-1:0] sine_from_phase(input logic [63:0] phase);
		logic [1:0]  quad;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		quad = phase[31:30];
		f = phase & (Q30_ONE - 64'd1);
		if (quad[0])
			f = Q30_ONE - f;
		x  = (f * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		r  = (s + 64'd4096) >> 13;
		return DATA_W'(quad[1] ? (64'd0 - r) : r);
	endfunction

endpackage

`default_nettype wire

// ----- design/force_pi_velocity_controller.sv -----
// Force PI velocity controller, top level; uses fpvc_pkg, fpvc_mul, fpvc_sine_rom.
// Operation and calibration: after the input transaction the sequencer runs ten steps, five of them on one
// 33x33 multiplier; no new transaction is taken until it is back in idle after loading the result.
// Passive mode: the transaction goes straight to the result step. Output stalls hold the sequencer.
// Reset: registers, accumulator, last error and elapsed time cleared to zero.
`default_nettype none

module force_pi_velocity_controller #(
	parameter int SINE_TABLE_SIZE = fpvc_pkg::SINE_TABLE_SIZE_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [fpvc_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [31:0]                          pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [fpvc_pkg::DATA_W-1:0]   measured_position,
	input  wire logic signed [fpvc_pkg::DATA_W-1:0]   measured_force,
	input  wire logic signed [fpvc_pkg::DATA_W-1:0]   target_position,
	input  wire logic signed [fpvc_pkg::DATA_W-1:0]   target_force,
	input  wire logic signed [fpvc_pkg::DATA_W-1:0]   target_velocity,
	input  wire logic [fpvc_pkg::DT_W-1:0]            time_step,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [fpvc_pkg::DATA_W-1:0]        velocity_command,
	output logic signed [fpvc_pkg::DATA_W-1:0]        force_command,
	output logic signed [fpvc_pkg::DATA_W-1:0]        position_command
);
	import fpvc_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_POS  = 11'b000_0000_0010,
		ST_FSET = 11'b000_0000_0100,
		ST_ERR  = 11'b000_0000_1000,
		ST_KI   = 11'b000_0001_0000,
		ST_PH   = 11'b000_0010_0000,
		ST_PL   = 11'b000_0100_0000,
		ST_KP   = 11'b000_1000_0000,
		ST_ACC1 = 11'b001_0000_0000,
		ST_ACC2 = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	state_t                     state_q;
	mode_t                      mode_q;
	logic signed [DATA_W-1:0]   pos_gain_q;
	logic signed [DATA_W-1:0]   kp_q;
	logic signed [DATA_W-1:0]   ki_q;
	logic signed [DATA_W-1:0]   acc_q;
	logic signed [DATA_W-1:0]   prev_q;
	logic [ELAPSED_W-1:0]       elapsed_q;
	logic                       out_valid_q;

	logic signed [DATA_W-1:0]   meas_force_q;
	logic signed [DATA_W-1:0]   tgt_force_q;
	logic signed [DATA_W-1:0]   tgt_vel_q;
	logic signed [DATA_W-1:0]   tgt_pos_q;
	logic signed [MUL_W-1:0]    perr_q;
	logic [DT_W-1:0]            dt_q;
	logic                       act_q;
	logic                       cal_q;
	logic signed [DATA_W-1:0]   fset_q;
	logic signed [DATA_W-1:0]   err_q;
	logic signed [MUL_W-1:0]    delta_q;
	logic [15:0]                pl_q;
	logic signed [SUM_W-1:0]    sum_q;

	logic signed [DATA_W-1:0]   vel_out_q;
	logic signed [DATA_W-1:0]   force_out_q;
	logic signed [DATA_W-1:0]   pos_out_q;

	logic                       cfg_wr;
	reg_idx_t                   cfg_idx;
	logic                       in_acc;
	logic                       mode_active;
	logic                       load_out;
	logic                       mul_en;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DATA_W-1:0]   sine_q;

	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite;
	assign cfg_idx     = reg_idx_t'(paddr[3:2]);
	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign mode_active = (mode_q == MODE_OPER) || (mode_q == MODE_CAL);
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		case (cfg_idx)
			REG_MODE:     prdata = 32'(mode_q);
			REG_POS_GAIN: prdata = pos_gain_q;
			REG_KP:       prdata = kp_q;
			REG_KI:       prdata = ki_q;
			default:      prdata = '0;
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_POS: begin
				mul_a = MUL_W'(pos_gain_q);
				mul_b = perr_q;
			end
			ST_KI: begin
				mul_a = MUL_W'(ki_q);
				mul_b = MUL_W'(err_q);
			end
			ST_PH: begin
				mul_a = MUL_W'($signed(prod_q[63:32]));
				mul_b = MUL_W'(dt_q);
			end
			ST_PL: begin
				mul_a = MUL_W'(pl_q);
				mul_b = MUL_W'(dt_q);
			end
			ST_KP: begin
				mul_a = MUL_W'(kp_q);
				mul_b = delta_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	fpvc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	fpvc_sine_rom #(
		.SINE_TABLE_SIZE (SINE_TABLE_SIZE)
	) u_sine (
		.clk     (clk),
		.elapsed (elapsed_q),
		.sine_q  (sine_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_PASSIVE;
			pos_gain_q  <= '0;
			kp_q        <= '0;
			ki_q        <= '0;
			acc_q       <= '0;
			prev_q      <= '0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_MODE: begin
						mode_q    <= mode_t'(pwdata[1:0]);
						acc_q     <= '0;
						elapsed_q <= '0;
					end
					REG_POS_GAIN: pos_gain_q <= pwdata;
					REG_KP:       kp_q       <= pwdata;
					REG_KI:       ki_q       <= pwdata;
					default: ;
				endcase
			end
			if (in_acc) begin
				elapsed_q <= elapsed_q + ELAPSED_W'(time_step);
			end
			if (state_q == ST_KI) begin
				prev_q <= err_q;
			end
			if (state_q == ST_ACC2) begin
				acc_q <= sat32(sum_q + SUM_W'(acc_q));
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= mode_active ? ST_POS : ST_DONE;
				end
				ST_POS:  state_q <= ST_FSET;
				ST_FSET: state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_KI;
				ST_KI:   state_q <= ST_PH;
				ST_PH:   state_q <= ST_PL;
				ST_PL:   state_q <= ST_KP;
				ST_KP:   state_q <= ST_ACC1;
				ST_ACC1: state_q <= ST_ACC2;
				ST_ACC2: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_force_q <= measured_force;
			tgt_force_q  <= target_force;
			tgt_vel_q    <= target_velocity;
			tgt_pos_q    <= target_position;
			perr_q       <= MUL_W'(target_position) - MUL_W'(measured_position);
			dt_q         <= time_step;
			act_q        <= mode_active;
			cal_q        <= (mode_q == MODE_CAL);
		end
		case (state_q)
			ST_FSET: begin
				fset_q <= cal_q ? sine_q
					: sat32(SUM_W'(tgt_force_q) + SUM_W'($signed(prod_q[PROD_W-1:16])));
			end
			ST_ERR:  err_q <= sat32(SUM_W'(fset_q) - SUM_W'(meas_force_q));
			ST_KI:   delta_q <= MUL_W'(err_q) - MUL_W'(prev_q);
			ST_PH:   pl_q <= prod_q[31:16];
			ST_PL:   sum_q <= $signed(prod_q[SUM_W-1:0]);
			ST_KP:   sum_q <= sum_q + $signed(SUM_W'(prod_q[31:16]));
			ST_ACC1: sum_q <= sum_q + SUM_W'($signed(prod_q[PROD_W-1:16]));
			default: ;
		endcase
		if (load_out) begin
			vel_out_q   <= act_q ? acc_q : tgt_vel_q;
			force_out_q <= act_q ? fset_q : tgt_force_q;
			pos_out_q   <= tgt_pos_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign velocity_command = vel_out_q;
	assign force_command    = force_out_q;
	assign position_command = pos_out_q;

endmodule

`default_nettype wire

// ----- design/fpvc_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on fpvc_pkg.
`default_nettype none

module fpvc_mul (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [fpvc_pkg::MUL_W-1:0]  a,
	input  wire logic signed [fpvc_pkg::MUL_W-1:0]  b,
	output logic signed [fpvc_pkg::PROD_W-1:0]      p_q
);
	import fpvc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

`default_nettype wire

// ----- design/fpvc_sine_rom.sv -----
// Calibration sine table: 2*sin over one wrap of the elapsed-time counter, indexed by elapsed time.
// Depends on fpvc_pkg; entries built at elaboration, read data registered.
`default_nettype none

module fpvc_sine_rom #(
	parameter int SINE_TABLE_SIZE = fpvc_pkg::SINE_TABLE_SIZE_DEF
) (
	input  wire logic                                 clk,
	input  wire logic [fpvc_pkg::ELAPSED_W-1:0]       elapsed,
	output logic signed [fpvc_pkg::DATA_W-1:0]        sine_q
);
	import fpvc_pkg::*;

	localparam int IDX_W = $clog2(SINE_TABLE_SIZE);
	localparam int SCL_W = ELAPSED_W + IDX_W;

	logic signed [DATA_W-1:0] rom [SINE_TABLE_SIZE];
	logic [SCL_W-1:0]         scaled;
	logic [IDX_W-1:0]         idx;

	genvar g;
	for (g = 0; g < SINE_TABLE_SIZE; g++) begin : g_rom
		localparam logic [63:0] PHASE = (64'(g) << 32) / 64'(SINE_TABLE_SIZE);
		localparam logic signed [DATA_W-1:0] ENTRY = sine_from_phase(PHASE);
		assign rom[g] = ENTRY;
	end

	assign scaled = SCL_W'(elapsed) * SCL_W'(SINE_TABLE_SIZE);
	assign idx    = scaled[ELAPSED_W +: IDX_W];

	always_ff @(posedge clk) begin
		sine_q <= rom[idx];
	end

endmodule

`default_nettype wire

// ----- design/fpvc_checker.sv -----
// Port-level checker for force_pi_velocity_controller, bound to the top level.
// Depends on force_pi_velocity_controller_macros.svh.
`default_nettype none
`include "force_pi_velocity_controller_macros.svh"

module fpvc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [31:0]  velocity_command,
	input wire logic [31:0]  force_command,
	input wire logic [31:0]  position_command
);

	// one transaction in flight at a time
	`FPVC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new result appears as the sequencer returns to idle
	`FPVC_ASSERT_SAME(a_idle_on_result, clk, arst_n, $rose(out_valid), in_ready)

	`FPVC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(velocity_command) && $stable(force_command) && $stable(position_command))

endmodule

bind force_pi_velocity_controller fpvc_checker u_fpvc_checker (.*);

`default_nettype wire
